// ===== src/bpvh_pkg.sv =====
// Shared types and constants of the B-spline partial-volume histogram block.
package bpvh_pkg;

  // Field widths.
  localparam int unsigned FRAC_W   = 16;
  localparam int unsigned TAP_W    = 16;
  localparam int unsigned WEIGHT_W = 18;
  localparam int unsigned ACC_W    = 48;
  localparam int unsigned BIN_W    = 5;
  localparam int unsigned NC_W     = 6;
  localparam int unsigned IDX_W    = 14;

  // Item modes.
  localparam logic [1:0] MODE_ACC   = 2'd0;
  localparam logic [1:0] MODE_READ  = 2'd1;
  localparam logic [1:0] MODE_CLEAR = 2'd2;

  // Configuration register indexes.
  localparam logic [1:0] REG_DEGREE = 2'd0;
  localparam logic [1:0] REG_BINS   = 2'd1;

  // Half of one in Q0.16.
  localparam logic [FRAC_W-1:0] HALF_Q16 = 16'd32768;

  // Request that starts one round of tap computation.
  typedef struct packed {
    logic              start;
    logic              cubic;
    logic [FRAC_W-1:0] ref_frac;
    logic [FRAC_W-1:0] cur_frac;
  } tap_req_t;

endpackage

// ===== src/bspline_partial_volume_histogram.sv =====
// Top level of the B-spline partial-volume joint histogram accumulator.
// After reset the block sweeps all 16*MAX_BINS*MAX_BINS entries (16384 at the
// default) of the accumulator memory to zero, one entry per cycle, and holds
// in_stall_o high until it is done; configuration writes are taken at all
// times. Every item gives one result transaction. In an accumulate item the
// eight taps pass one per cycle through the tap pipeline, then comes one
// read-modify-write of the accumulator memory per cycle (9 or 16 of them)
// and a drain of the update pipeline. A read passes through the read state
// and a clear does not. A finished result waits in an output register, so
// the next item is taken while it waits. Items whose cell or index is out of
// range are dropped and flagged.
module bspline_partial_volume_histogram #(
  parameter int unsigned MAX_BINS = 32
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [1:0]                          mode_i,
  input  logic [bpvh_pkg::BIN_W-1:0]          ref_bin_i,
  input  logic [bpvh_pkg::FRAC_W-1:0]         ref_frac_i,
  input  logic [bpvh_pkg::BIN_W-1:0]          cur_bin_i,
  input  logic [bpvh_pkg::FRAC_W-1:0]         cur_frac_i,
  input  logic [bpvh_pkg::WEIGHT_W-1:0]       sample_weight_i,
  input  logic [bpvh_pkg::IDX_W-1:0]          entry_index_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [bpvh_pkg::ACC_W-1:0]          entry_value_o,
  output logic                                range_error_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [1:0]                          cfg_index_i,
  input  logic [bpvh_pkg::NC_W-1:0]           cfg_data_i
);

  localparam int unsigned DEPTH = 16 * MAX_BINS * MAX_BINS;
  localparam int unsigned AW    = $clog2(DEPTH);

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_TAPS,
    S_UPDATE,
    S_DRAIN,
    S_READ,
    S_FINISH
  } state_e;

  state_e                          state_q;
  logic [AW-1:0]                   clr_cnt_q;
  logic                            degree_q;
  logic [bpvh_pkg::NC_W-1:0]       bins_q;
  logic                            cubic_q;
  logic [bpvh_pkg::WEIGHT_W-1:0]   w_q;
  logic [AW-1:0]                   base_q;
  logic [1:0]                      r_q, c_q;
  logic                            p0_valid_q, p1_valid_q;
  logic [31:0]                     p0_rc_q;
  logic [AW-1:0]                   p0_addr_q, p1_addr_q;
  logic [50:0]                     p1_prod_q;
  logic [bpvh_pkg::ACC_W-1:0]      res_value_q;
  logic                            res_err_q;
  logic                            out_valid_q;
  logic [bpvh_pkg::ACC_W-1:0]      entry_value_q;
  logic                            range_error_q;

  // Cell decode and range checks of the item at the input.
  logic                            accept;
  logic                            row_shift, col_shift;
  logic [5:0]                      row, col;
  logic                            cfg_over;
  logic                            cell_err;
  logic [11:0]                     cell_num;
  logic [15:0]                     base;
  logic                            idx_ok;
  logic [AW-1:0]                   idx_addr;

  assign in_stall_o = (state_q != S_IDLE);
  assign accept     = in_valid_i && (state_q == S_IDLE);

  always_comb begin
    row_shift = !degree_q && (ref_frac_i > bpvh_pkg::HALF_Q16);
    col_shift = !degree_q && (cur_frac_i > bpvh_pkg::HALF_Q16);
    row       = {1'b0, ref_bin_i} + {5'b0, row_shift};
    col       = {1'b0, cur_bin_i} + {5'b0, col_shift};
    cfg_over  = {4'b0, bins_q} > 10'(MAX_BINS);
    cell_err  = cfg_over || (row >= bins_q) || (col >= bins_q);
    cell_num  = 12'({6'b0, row} * {6'b0, bins_q}) + {6'b0, col};
    base      = degree_q ? {cell_num, 4'b0}
                         : (({4'b0, cell_num} << 3) + {4'b0, cell_num});
    idx_ok    = 32'(entry_index_i) < DEPTH;
    idx_addr  = AW'(entry_index_i);
  end

  // Tap unit.
  bpvh_pkg::tap_req_t               tap_req;
  logic                             tap_done;
  logic [bpvh_pkg::TAP_W-1:0]       row_tap, col_tap;

  always_comb begin
    tap_req.start    = accept && (mode_i == bpvh_pkg::MODE_ACC) && !cell_err;
    tap_req.cubic    = degree_q;
    tap_req.ref_frac = ref_frac_i;
    tap_req.cur_frac = cur_frac_i;
  end

  bpvh_tap_unit u_taps (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (tap_req),
    .r_sel_i   (r_q),
    .c_sel_i   (c_q),
    .done_o    (tap_done),
    .row_tap_o (row_tap),
    .col_tap_o (col_tap)
  );

  // Tap walk over the cell.
  logic [1:0] last;
  logic [3:0] off;

  always_comb begin
    last = cubic_q ? 2'd3 : 2'd2;
    off  = cubic_q ? {r_q, c_q} : ({1'b0, r_q, 1'b0} + {2'b0, r_q} + {2'b0, c_q});
  end

  // Memory ports: sweep, update write-back and clear share the write port.
  logic                        mem_we, mem_re;
  logic [AW-1:0]               mem_waddr, mem_raddr;
  logic [bpvh_pkg::ACC_W-1:0]  mem_wdata, mem_rdata;
  logic [50:0]                 round_sum;
  logic [48:0]                 acc_sum;

  always_comb begin
    round_sum = p1_prod_q + 51'h0_8000_0000;
    acc_sum   = {1'b0, mem_rdata} + 49'(round_sum[50:32]);
    mem_we    = 1'b0;
    mem_waddr = clr_cnt_q;
    mem_wdata = '0;
    if (state_q == S_INIT) begin
      mem_we = 1'b1;
    end else if (p1_valid_q) begin
      mem_we    = 1'b1;
      mem_waddr = p1_addr_q;
      mem_wdata = acc_sum[48] ? {bpvh_pkg::ACC_W{1'b1}} : acc_sum[47:0];
    end else if (accept && (mode_i == bpvh_pkg::MODE_CLEAR) && idx_ok) begin
      mem_we    = 1'b1;
      mem_waddr = idx_addr;
    end
    mem_re    = 1'b0;
    mem_raddr = idx_addr;
    if (p0_valid_q) begin
      mem_re    = 1'b1;
      mem_raddr = p0_addr_q;
    end else if (accept && (mode_i == bpvh_pkg::MODE_READ) && idx_ok) begin
      mem_re = 1'b1;
    end
  end

  bpvh_store #(
    .DEPTH (DEPTH),
    .AW    (AW),
    .DW    (bpvh_pkg::ACC_W)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // Sequencer, configuration registers, update pipeline and result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_INIT;
      clr_cnt_q     <= '0;
      degree_q      <= 1'b0;
      bins_q        <= 6'd32;
      cubic_q       <= 1'b0;
      w_q           <= '0;
      base_q        <= '0;
      r_q           <= '0;
      c_q           <= '0;
      p0_valid_q    <= 1'b0;
      p1_valid_q    <= 1'b0;
      p0_rc_q       <= '0;
      p0_addr_q     <= '0;
      p1_addr_q     <= '0;
      p1_prod_q     <= '0;
      res_value_q   <= '0;
      res_err_q     <= 1'b0;
      out_valid_q   <= 1'b0;
      entry_value_q <= '0;
      range_error_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        if (cfg_index_i == bpvh_pkg::REG_DEGREE) begin
          degree_q <= cfg_data_i[0];
        end else if (cfg_index_i == bpvh_pkg::REG_BINS) begin
          bins_q <= cfg_data_i;
        end
      end
      if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      p0_valid_q <= 1'b0;
      p1_valid_q <= p0_valid_q;
      p1_addr_q  <= p0_addr_q;
      p1_prod_q  <= 51'(p0_rc_q) * 51'(w_q);
      unique case (state_q)
        S_INIT: begin
          clr_cnt_q <= clr_cnt_q + 1'b1;
          if (clr_cnt_q == AW'(DEPTH - 1)) begin
            state_q <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid_i) begin
            res_value_q <= '0;
            res_err_q   <= 1'b0;
            w_q         <= sample_weight_i;
            cubic_q     <= degree_q;
            base_q      <= AW'(base);
            r_q         <= '0;
            c_q         <= '0;
            unique case (mode_i)
              bpvh_pkg::MODE_ACC: begin
                if (cell_err) begin
                  res_err_q <= 1'b1;
                  state_q   <= S_FINISH;
                end else begin
                  state_q <= S_TAPS;
                end
              end
              bpvh_pkg::MODE_READ: begin
                if (idx_ok) begin
                  state_q <= S_READ;
                end else begin
                  res_err_q <= 1'b1;
                  state_q   <= S_FINISH;
                end
              end
              bpvh_pkg::MODE_CLEAR: begin
                res_err_q <= !idx_ok;
                state_q   <= S_FINISH;
              end
              default: state_q <= S_FINISH;
            endcase
          end
        end
        S_TAPS: begin
          if (tap_done) begin
            state_q <= S_UPDATE;
          end
        end
        S_UPDATE: begin
          p0_valid_q <= 1'b1;
          p0_rc_q    <= 32'(row_tap) * 32'(col_tap);
          p0_addr_q  <= base_q + AW'(off);
          if (c_q == last) begin
            c_q <= '0;
            if (r_q == last) begin
              state_q <= S_DRAIN;
            end else begin
              r_q <= r_q + 2'd1;
            end
          end else begin
            c_q <= c_q + 2'd1;
          end
        end
        S_DRAIN: begin
          if (!p0_valid_q && !p1_valid_q) begin
            state_q <= S_FINISH;
          end
        end
        S_READ: begin
          res_value_q <= mem_rdata;
          state_q     <= S_FINISH;
        end
        S_FINISH: begin
          if (!out_valid_q || !out_stall_i) begin
            out_valid_q   <= 1'b1;
            entry_value_q <= res_value_q;
            range_error_q <= res_err_q;
            state_q       <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign cfg_ready_o   = 1'b1;
  assign out_valid_o   = out_valid_q;
  assign entry_value_o = entry_value_q;
  assign range_error_o = range_error_q;

endmodule

// ===== src/bpvh_store.sv =====
// Accumulator memory with one write port and one registered read port.
module bpvh_store #(
  parameter int unsigned DEPTH = 16384,
  parameter int unsigned AW    = 14,
  parameter int unsigned DW    = 48
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [DW-1:0] wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [DW-1:0] rdata_o
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rdata_q;

  // Write and read in the same clock; a read sees writes from earlier edges.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/bpvh_tap_unit.sv =====
// Pipelined unit that computes the four row and four column B-spline taps.
module bpvh_tap_unit (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  bpvh_pkg::tap_req_t               req_i,
  input  logic [1:0]                       r_sel_i,
  input  logic [1:0]                       c_sel_i,
  output logic                             done_o,
  output logic [bpvh_pkg::TAP_W-1:0]       row_tap_o,
  output logic [bpvh_pkg::TAP_W-1:0]       col_tap_o
);

  typedef enum logic [2:0] {
    K_ZERO,
    K_QCTR,
    K_QSIDE,
    K_CEND,
    K_CMID
  } kind_e;

  logic                           cubic_q;
  logic [bpvh_pkg::FRAC_W-1:0]    rfrac_q;
  logic [bpvh_pkg::FRAC_W-1:0]    cfrac_q;
  logic                           issue_q;
  logic [2:0]                     k_q;

  // Stage 0: select the base value of the tap.
  logic [bpvh_pkg::FRAC_W-1:0]    f;
  logic [1:0]                     j;
  logic                           shift;
  logic signed [17:0]             er;
  logic signed [18:0]             er_x;
  logic signed [18:0]             d;
  logic [17:0]                    a;
  logic [16:0]                    u;
  logic [16:0]                    v;
  logic [16:0]                    x0;
  kind_e                          kind0;

  always_comb begin
    f     = k_q[2] ? cfrac_q : rfrac_q;
    j     = k_q[1:0];
    shift = f > bpvh_pkg::HALF_Q16;
    er    = shift ? ($signed({2'b00, f}) - 18'sd65536) : $signed({2'b00, f});
    er_x  = {er[17], er};
    unique case (j)
      2'd0:    d = -19'sd65536 - er_x;
      2'd1:    d = -er_x;
      default: d = 19'sd65536 - er_x;
    endcase
    a = d[18] ? 18'(-d) : 18'(d);
    u = {1'b0, f};
    v = 17'd65536 - u;
    x0    = '0;
    kind0 = K_ZERO;
    if (cubic_q) begin
      unique case (j)
        2'd0:    begin x0 = v; kind0 = K_CEND; end
        2'd1:    begin x0 = u; kind0 = K_CMID; end
        2'd2:    begin x0 = v; kind0 = K_CMID; end
        default: begin x0 = u; kind0 = K_CEND; end
      endcase
    end else if (j != 2'd3) begin
      if (a < 18'd32768) begin
        x0    = a[16:0];
        kind0 = K_QCTR;
      end else if (a < 18'd98304) begin
        x0    = 17'(18'd98304 - a);
        kind0 = K_QSIDE;
      end
    end
  end

  // Pipeline registers: a holds the base, b the square, c the cube.
  logic        a_v_q, b_v_q, c_v_q, d_v_q, e_v_q;
  logic [2:0]  a_k_q, b_k_q, c_k_q, d_k_q, e_k_q;
  kind_e       a_kind_q, b_kind_q, c_kind_q;
  logic [16:0] a_x_q, b_x_q;
  logic [33:0] b_sq_q, c_sq_q;
  logic [50:0] c_cube_q;
  logic        d_quad_q, e_quad_q;
  logic [bpvh_pkg::TAP_W-1:0] d_qtap_q, e_qtap_q;
  logic [17:0] d_y_q, e_y_q;
  logic [16:0] e_q0_q;

  // Stage d: finish quadratic taps, form the cubic numerator over 2^33.
  logic [33:0] ctr_sum;
  logic [33:0] side_sum;
  logic [51:0] num;
  logic [bpvh_pkg::TAP_W-1:0] qtap_d;
  logic        quad_d;

  always_comb begin
    ctr_sum  = 34'd3221225472 - c_sq_q + 34'd32768;
    side_sum = c_sq_q + 34'd65536;
    if (c_kind_q == K_CMID) begin
      num = 52'({c_cube_q, 1'b0}) + 52'(c_cube_q) + (52'd1 << 50) + 52'h3_0000_0000
            - 52'({c_sq_q, 17'b0}) - 52'({c_sq_q, 18'b0});
    end else begin
      num = 52'(c_cube_q) + 52'h3_0000_0000;
    end
    quad_d = 1'b1;
    unique case (c_kind_q)
      K_QCTR:  qtap_d = ctr_sum[31:16];
      K_QSIDE: qtap_d = side_sum[32:17];
      K_CEND, K_CMID: begin
        qtap_d = '0;
        quad_d = 1'b0;
      end
      default: qtap_d = '0;
    endcase
  end

  // Stage e result: divide by three with one correction step.
  logic [33:0] recip_prod;
  logic [18:0] three_q;
  logic [18:0] rem;
  logic [16:0] q;
  logic [bpvh_pkg::TAP_W-1:0] tap_fin;

  always_comb begin
    recip_prod = 34'(d_y_q) * 34'd43690;
    three_q    = {2'b00, e_q0_q} + {1'b0, e_q0_q, 1'b0};
    rem        = {1'b0, e_y_q} - three_q;
    q          = (rem >= 19'd3) ? (e_q0_q + 17'd1) : e_q0_q;
    tap_fin    = e_quad_q ? e_qtap_q : q[bpvh_pkg::TAP_W-1:0];
  end

  logic [bpvh_pkg::TAP_W-1:0] rtap_q [4];
  logic [bpvh_pkg::TAP_W-1:0] ctap_q [4];

  // Issue sequencer and valid chain.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      issue_q <= 1'b0;
      k_q     <= '0;
      cubic_q <= 1'b0;
      a_v_q   <= 1'b0;
      b_v_q   <= 1'b0;
      c_v_q   <= 1'b0;
      d_v_q   <= 1'b0;
      e_v_q   <= 1'b0;
    end else begin
      if (req_i.start) begin
        issue_q <= 1'b1;
        k_q     <= '0;
        cubic_q <= req_i.cubic;
      end else if (issue_q) begin
        k_q <= k_q + 3'd1;
        if (k_q == 3'd7) begin
          issue_q <= 1'b0;
        end
      end
      a_v_q <= issue_q;
      b_v_q <= a_v_q;
      c_v_q <= b_v_q;
      d_v_q <= c_v_q;
      e_v_q <= d_v_q;
    end
  end

  // Datapath registers of the tap pipeline.
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rfrac_q <= req_i.ref_frac;
      cfrac_q <= req_i.cur_frac;
    end
    a_k_q    <= k_q;
    a_kind_q <= kind0;
    a_x_q    <= x0;
    b_k_q    <= a_k_q;
    b_kind_q <= a_kind_q;
    b_x_q    <= a_x_q;
    b_sq_q   <= 34'(a_x_q) * 34'(a_x_q);
    c_k_q    <= b_k_q;
    c_kind_q <= b_kind_q;
    c_sq_q   <= b_sq_q;
    c_cube_q <= 51'(b_sq_q) * 51'(b_x_q);
    d_k_q    <= c_k_q;
    d_quad_q <= quad_d;
    d_qtap_q <= qtap_d;
    d_y_q    <= num[50:33];
    e_k_q    <= d_k_q;
    e_quad_q <= d_quad_q;
    e_qtap_q <= d_qtap_q;
    e_y_q    <= d_y_q;
    e_q0_q   <= recip_prod[33:17];
    if (e_v_q) begin
      if (e_k_q[2]) begin
        ctap_q[e_k_q[1:0]] <= tap_fin;
      end else begin
        rtap_q[e_k_q[1:0]] <= tap_fin;
      end
    end
  end

  assign done_o    = e_v_q && (e_k_q == 3'd7);
  assign row_tap_o = rtap_q[r_sel_i];
  assign col_tap_o = ctap_q[c_sel_i];

endmodule

// ===== src/bpvh_checker.sv =====
// Port-level assertions for the histogram block and the bind that attaches them.
module bpvh_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_stall_o,
  input logic                          out_valid_o,
  input logic                          out_stall_i,
  input logic [bpvh_pkg::ACC_W-1:0]    entry_value_o,
  input logic                          range_error_o
);

  // A stalled result stays offered.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result withdrawn while stalled");

  // A stalled result keeps its payload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(entry_value_o) && $stable(range_error_o))
    else $error("result payload changed while stalled");

  // A dropped item never reports a value.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && range_error_o |-> entry_value_o == '0)
    else $error("flagged result carries a value");

  // One item at a time: after an input transaction the input stalls.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("second item taken while one is in work");

endmodule

bind bspline_partial_volume_histogram bpvh_checker u_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_stall_o    (in_stall_o),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .entry_value_o (entry_value_o),
  .range_error_o (range_error_o)
);
